// ===== hdl/bf3s2_pkg.sv =====
`timescale 1ns / 1ps

package bf3s2_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int SIDE_BITS   = 11;
   localparam int INDEX_BITS  = 9;
   localparam int SIDE_RESET  = 1024;

   // Three samples per column, nine per window
   localparam int COL_BITS = SAMPLE_BITS + 2;
   localparam int SUM_BITS = SAMPLE_BITS + 4;

   // floor(x / 9) == (x * ceil(2^24 / 9)) >> 24 for every x below 2^20
   localparam int RECIP_SHIFT = SUM_BITS + 4;
   localparam int RECIP_BITS  = 21;
   localparam logic [RECIP_BITS-1:0] RECIP_NINE = 21'd1864136;
   localparam int PROD_BITS   = SUM_BITS + RECIP_BITS;

   typedef logic [SAMPLE_BITS-1:0] sample_type;
   typedef logic [SIDE_BITS-1:0]   side_type;
   typedef logic [INDEX_BITS-1:0]  index_type;
   typedef logic [COL_BITS-1:0]    col_sum_type;
   typedef logic [SUM_BITS-1:0]    win_sum_type;

endpackage

// ===== hdl/bf3s2_sample_if.sv =====
`timescale 1ns / 1ps

interface bf3s2_sample_if;
   import bf3s2_pkg::*;

   logic       valid;
   logic       ready;
   sample_type sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

// ===== hdl/bf3s2_result_if.sv =====
`timescale 1ns / 1ps

interface bf3s2_result_if;
   import bf3s2_pkg::*;

   logic       valid;
   logic       ready;
   sample_type average;
   index_type  out_row;
   index_type  out_col;
   logic       last;

   modport source (output valid, output average, output out_row, output out_col,
                   output last, input ready);
   modport sink (input valid, input average, input out_row, input out_col,
                 input last, output ready);
endinterface

// ===== hdl/bf3s2_csr_if.sv =====
`timescale 1ns / 1ps

interface bf3s2_csr_if;
   import bf3s2_pkg::*;

   logic     valid;
   logic     ready;
   side_type side_length;

   modport source (output valid, output side_length, input ready);
   modport sink (input valid, input side_length, output ready);
endinterface

// ===== hdl/box_filter_3x3_stride2.sv =====
// 3x3 box filter with downsampling by 2, one sample per item in raster order.
// Registers from sample accept to result valid: input/line-read register,
// window-sum register, divide-by-9 output register. Throughput: 1 item per cycle while
// the output is not stalled, bounded by the line stores doing one read and one write per cycle.
// Reset (synchronous): counters, valids and column sums clear, side goes to 1024 (or MAX_SIDE if smaller).
// Line stores are not cleared; the row counter keeps unwritten entries from being used.
`timescale 1ns / 1ps

module box_filter_3x3_stride2 #(
   parameter int MAX_SIDE = 1024
) (
   input logic            clock,
   input logic            reset,
   bf3s2_sample_if.sink   req_ch,
   bf3s2_result_if.source rsp_ch,
   bf3s2_csr_if.sink      csr_ch
);
   import bf3s2_pkg::*;

   localparam int CW         = $clog2(MAX_SIDE);
   localparam int RESET_SIDE = (MAX_SIDE < SIDE_RESET) ? MAX_SIDE : SIDE_RESET;

   // ---------------------------------------------------------------------
   // Side register, kept as side-1 after clamping to [1, MAX_SIDE]
   // ---------------------------------------------------------------------
   logic [CW-1:0] dim_m1_ff, dim_m1_in;
   logic          csr_write;

   assign csr_ch.ready = 1'b1;
   assign csr_write    = csr_ch.valid && csr_ch.ready;

   always_comb begin
      if (csr_ch.side_length == '0) begin
         dim_m1_in = '0;
      end else if (32'(csr_ch.side_length) > 32'(MAX_SIDE)) begin
         dim_m1_in = CW'(MAX_SIDE - 1);
      end else begin
         dim_m1_in = CW'(csr_ch.side_length - side_type'(1));
      end
   end

   // ---------------------------------------------------------------------
   // Pipeline control: each stage moves when the one after it has room
   // ---------------------------------------------------------------------
   logic p1_valid_ff, p2_valid_ff, rsp_valid_ff;
   logic en1, en2, en3, req_accept;

   assign en3        = !rsp_valid_ff || rsp_ch.ready;
   assign en2        = !p2_valid_ff || en3;
   assign en1        = !p1_valid_ff || en2;
   assign req_ch.ready = en1;
   assign req_accept = req_ch.valid && en1;

   // ---------------------------------------------------------------------
   // Row / column counters, advanced per accepted item
   // ---------------------------------------------------------------------
   logic [CW-1:0] row_ff, col_ff;
   logic          last_row, last_col;

   assign last_row = (row_ff == dim_m1_ff);
   assign last_col = (col_ff == dim_m1_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_m1_ff <= CW'(RESET_SIDE - 1);
         row_ff    <= '0;
         col_ff    <= '0;
      end else if (csr_write) begin
         dim_m1_ff <= dim_m1_in;
         row_ff    <= '0;
         col_ff    <= '0;
      end else if (req_accept) begin
         if (last_col) begin
            col_ff <= '0;
            row_ff <= last_row ? '0 : row_ff + CW'(1);
         end else begin
            col_ff <= col_ff + CW'(1);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: sample, window flags, registered line store read
   // ---------------------------------------------------------------------
   sample_type    p1_sample_ff;
   logic [CW-1:0] p1_idx_ff;
   logic          p1_row_odd_ff, p1_r_ge1_ff, p1_r_ge2_ff;
   logic          p1_col_odd_ff, p1_first_col_ff, p1_emit_ff, p1_last_ff;
   index_type     p1_out_row_ff, p1_out_col_ff;

   // old_row_mem: two rows up; prev_row_mem: one row up
   sample_type old_row_mem  [MAX_SIDE];
   sample_type prev_row_mem [MAX_SIDE];
   sample_type rd_old_ff, rd_prev_ff;
   logic       fwd_hit;

   // Back-to-back items at the same column (one-column image) read what
   // the item ahead writes in the same cycle: take it from the pipeline.
   assign fwd_hit = p1_valid_ff && en2 && (p1_idx_ff == col_ff);

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rd_old_ff  <= fwd_hit ? rd_prev_ff : old_row_mem[col_ff];
         rd_prev_ff <= fwd_hit ? p1_sample_ff : prev_row_mem[col_ff];
      end
      if (p1_valid_ff && en2) begin
         old_row_mem[p1_idx_ff]  <= rd_prev_ff;
         prev_row_mem[p1_idx_ff] <= p1_sample_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (en1) begin
         p1_valid_ff <= req_accept;
      end
      if (req_accept) begin
         p1_sample_ff    <= req_ch.sample;
         p1_idx_ff       <= col_ff;
         p1_row_odd_ff   <= row_ff[0];
         p1_r_ge1_ff     <= (row_ff != '0);
         p1_r_ge2_ff     <= (row_ff > CW'(1));
         p1_col_odd_ff   <= col_ff[0];
         p1_first_col_ff <= (col_ff == '0);
         p1_emit_ff      <= (row_ff[0] || last_row) && (col_ff[0] || last_col);
         p1_last_ff      <= last_row && last_col;
         // centre row/col halved: r>>1 whether r is odd or the even last row
         p1_out_row_ff   <= INDEX_BITS'(row_ff >> 1);
         p1_out_col_ff   <= INDEX_BITS'(col_ff >> 1);
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: column sums and the window sum
   // ---------------------------------------------------------------------
   sample_type  top, mid, bot;
   col_sum_type col_now, prev_eff, prev2_eff;
   col_sum_type col_prev_ff, col_prev2_ff;
   win_sum_type win_sum;
   win_sum_type p2_sum_ff;
   index_type   p2_out_row_ff, p2_out_col_ff;
   logic        p2_last_ff;

   always_comb begin
      if (p1_row_odd_ff) begin
         top = p1_r_ge2_ff ? rd_old_ff : '0;
         mid = rd_prev_ff;
         bot = p1_sample_ff;
      end else begin
         top = p1_r_ge1_ff ? rd_prev_ff : '0;
         mid = p1_sample_ff;
         bot = '0;
      end
      col_now   = COL_BITS'(top) + COL_BITS'(mid) + COL_BITS'(bot);
      // columns outside the image count as zero
      prev_eff  = p1_first_col_ff ? '0 : col_prev_ff;
      prev2_eff = (p1_first_col_ff || !p1_col_odd_ff) ? '0 : col_prev2_ff;
      win_sum   = SUM_BITS'(col_now) + SUM_BITS'(prev_eff) + SUM_BITS'(prev2_eff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff  <= 1'b0;
         col_prev_ff  <= '0;
         col_prev2_ff <= '0;
      end else if (en2) begin
         p2_valid_ff <= p1_valid_ff && p1_emit_ff;
         if (p1_valid_ff) begin
            col_prev2_ff <= prev_eff;
            col_prev_ff  <= col_now;
         end
      end
      if (en2 && p1_valid_ff && p1_emit_ff) begin
         p2_sum_ff     <= win_sum;
         p2_out_row_ff <= p1_out_row_ff;
         p2_out_col_ff <= p1_out_col_ff;
         p2_last_ff    <= p1_last_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: divide by 9 through the reciprocal, into the output register
   // ---------------------------------------------------------------------
   logic [PROD_BITS-1:0] prod;
   sample_type           avg_ff;
   index_type            out_row_ff, out_col_ff;
   logic                 last_ff;

   assign prod = PROD_BITS'(p2_sum_ff) * PROD_BITS'(RECIP_NINE);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en3) begin
         rsp_valid_ff <= p2_valid_ff;
      end
      if (en3 && p2_valid_ff) begin
         avg_ff     <= prod[RECIP_SHIFT +: SAMPLE_BITS];
         out_row_ff <= p2_out_row_ff;
         out_col_ff <= p2_out_col_ff;
         last_ff    <= p2_last_ff;
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.average = avg_ff;
   assign rsp_ch.out_row = out_row_ff;
   assign rsp_ch.out_col = out_col_ff;
   assign rsp_ch.last    = last_ff;

   // ---------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------
`ifndef SYNTHESIS
   // a side write restarts the frame
   a_csr_restart: assert property (@(posedge clock) disable iff (reset)
      csr_write |=> (row_ff == '0 && col_ff == '0))
      else $error("counters not cleared by side write");

   // counters never run past the image
   a_counter_range: assert property (@(posedge clock) disable iff (reset)
      (row_ff <= dim_m1_ff) && (col_ff <= dim_m1_ff))
      else $error("row/column counter beyond side");

   // the final result of a square frame sits on the diagonal
   a_last_diag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && last_ff) |-> (out_row_ff == out_col_ff))
      else $error("last result off the diagonal");

   // a window sum waiting behind a stalled output is kept
   a_p2_hold: assert property (@(posedge clock) disable iff (reset)
      (p2_valid_ff && !en3) |=> (p2_valid_ff && $stable(p2_sum_ff)))
      else $error("window sum lost while output stalled");
`endif

endmodule
